// File: rtl/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared widths, codes and types for the page mapping table.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int PAGE_BYTES_DEF    = 4096;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int PID_W    = 15;
  localparam int PAGE_W   = 20;
  localparam int ADDR_W   = 32;
  localparam int FRAME_W  = 16;
  localparam int FCOUNT_W = 17;
  localparam int STATUS_W = 3;
  localparam int PHYS_W   = 28;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 17'd65536;

  localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_XLATE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STATE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd4;

  // One stored mapping; the valid bit lives in flops beside the memory.
  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic               writable;
  } pmt_entry_t;

  // Commands from the sequencer to the table store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_one;
    logic clr_all;
  } pmt_cmd_t;

endpackage

// File: rtl/pmt_if.sv
// ----------------------------------------------------------------------------
// pmt_if
// Request and response channels of the page mapping table.
// ----------------------------------------------------------------------------
interface pmt_req_if import pmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [PID_W-1:0]    process_id;
  logic [PAGE_W-1:0]   page_number;
  logic [ADDR_W-1:0]   address;
  logic [FRAME_W-1:0]  frame_number;
  logic                write_enable;
  logic                process_live;
  logic                frame_in_use;

  modport source (
    output valid, action, process_id, page_number, address, frame_number,
           write_enable, process_live, frame_in_use,
    input  ready
  );
  modport sink (
    input  valid, action, process_id, page_number, address, frame_number,
           write_enable, process_live, frame_in_use,
    output ready
  );
endinterface

interface pmt_rsp_if import pmt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PHYS_W-1:0]   physical_address;

  modport source (output valid, status, physical_address, input ready);
  modport sink (input valid, status, physical_address, output ready);
endinterface

// File: rtl/pmt_store.sv
// ----------------------------------------------------------------------------
// pmt_store
// Mapping memory with registered read and per-entry valid flops.
// ----------------------------------------------------------------------------
module pmt_store import pmt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  pmt_cmd_t         cmd,
  input  logic [IDX_W-1:0] rd_addr,
  input  logic [IDX_W-1:0] wr_addr,
  input  pmt_entry_t       wr_data,
  output pmt_entry_t       rd_data,
  output logic             rd_valid
);

  pmt_entry_t               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Drop all entries at once on reset or clear.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      valid <= '0;
    end else begin
      if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.clr_one) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// File: rtl/page_mapping_table_translate.sv
// ----------------------------------------------------------------------------
// page_mapping_table_translate
// Associative (process id, page) -> (frame, writable) table with translate.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready request channel carrying action, process id, page,
//          address, frame, writable flag and the live/allocated flags.
//   rsp  : valid/ready response channel, one response per request, carrying
//          status and physical address (zero unless a translate succeeds).
//   cfg  : cfg_we/cfg_wdata write frame_count; write only while idle.
// Timing:
//   Clear and requests rejected by the pid/live/frame checks skip the walk
//   and go straight to the response state. Map, unmap and translate walk the
//   table one entry a cycle through the single memory read port; a hit stops
//   the walk for every action.
//   One request is in flight at a time; the next is taken once the response
//   has moved into the output register.
// Reset: all mappings invalid, frame_count = 65536, no response pending.
// Stall: the response holds in the output register while rsp.ready is low;
//   a new request may be accepted and processed, and its response waits.
// ----------------------------------------------------------------------------
module page_mapping_table_translate import pmt_pkg::*; #(
  parameter int PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  pmt_req_if.sink             req,
  pmt_rsp_if.source           rsp,
  input  logic                cfg_we,
  input  logic [FCOUNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]          state;
  logic [FCOUNT_W-1:0] frame_count;

  // Request held for the walk
  logic [ACTION_W-1:0] act;
  logic [PID_W-1:0]    pid;
  logic [PAGE_W-1:0]   key_page;
  logic                key_ok;
  logic [FRAME_W-1:0]  frame;
  logic                wr_flag;
  logic [OFF_W-1:0]    offset;

  // Walk bookkeeping
  logic [CNT_W-1:0] issue;
  logic             cmp_v;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [FRAME_W-1:0] hit_frame;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Result waiting for the output register, and the output register
  logic [STATUS_W-1:0] res_status;
  logic [PHYS_W-1:0]   res_phys;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PHYS_W-1:0]   out_phys;

  // Store connections
  pmt_cmd_t         cmd;
  logic [IDX_W-1:0] wr_addr;
  pmt_entry_t       wr_data;
  pmt_entry_t       rd_data;
  logic             rd_valid;

  logic                accept;
  logic                out_load;
  logic [ADDR_W-1:0]   vpage_full;
  logic                pre_done;
  logic [STATUS_W-1:0] pre_status;
  logic                hit_now;
  logic [47:0]         phys_wide;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_RESP) && (!out_valid || rsp.ready);

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.physical_address = out_phys;

  // Split the translate address; a page too wide for the key matches nothing.
  assign vpage_full = req.address >> OFF_W;

  // Checks that need no table access, in priority order.
  always_comb begin
    pre_done   = 1'b1;
    pre_status = ST_OK;
    if (req.action == ACT_CLEAR) begin
      pre_status = ST_OK;
    end else if (req.process_id == '0) begin
      pre_status = ST_RANGE;
    end else if (!req.process_live) begin
      pre_status = ST_NOT_FOUND;
    end else if (req.action == ACT_MAP && {1'b0, req.frame_number} >= frame_count) begin
      pre_status = ST_RANGE;
    end else if (req.action == ACT_MAP && !req.frame_in_use) begin
      pre_status = ST_STATE;
    end else begin
      pre_done = 1'b0;
    end
  end

  assign hit_now = cmp_v && rd_valid && key_ok &&
                   (rd_data.pid == pid) && (rd_data.page == key_page);

  assign phys_wide = 48'({hit_frame, offset});

  // Store commands: read while walking, update once in the finish state, and clear all when a clear is accepted.
  always_comb begin
    cmd         = '0;
    cmd.rd_en   = (state == S_SCAN) && (issue < ENTRY_CNT);
    cmd.clr_all = accept && (req.action == ACT_CLEAR);
    cmd.wr_en   = (state == S_FINISH) && (act == ACT_MAP) && !hit && free_found;
    cmd.clr_one = (state == S_FINISH) && (act == ACT_UNMAP) && hit;
    wr_addr     = (act == ACT_MAP) ? free_idx : hit_idx;
    wr_data     = '{pid: pid, page: key_page, frame: frame, writable: wr_flag};
  end

  pmt_store #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_addr (issue[IDX_W-1:0]),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_valid(rd_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FCOUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmp_v      <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmp_v      <= 1'b0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            issue      <= '0;
            res_status <= pre_status;
            res_phys   <= '0;
            state      <= pre_done ? S_RESP : S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle; compare the entry whose read was issued in the cycle before.
          if (cmd.rd_en) begin
            issue <= issue + CNT_W'(1);
          end
          cmp_v   <= cmd.rd_en;
          cmp_idx <= issue[IDX_W-1:0];
          if (cmp_v) begin
            if (hit_now) begin
              hit       <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_frame <= rd_data.frame;
              state     <= S_FINISH;
            end else begin
              if (!rd_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= cmp_idx;
              end
              if (cmp_idx == LAST_IDX) begin
                state <= S_FINISH;
              end
            end
          end
        end
        S_FINISH: begin
          res_phys <= '0;
          case (act)
            ACT_MAP: begin
              if (hit) begin
                res_status <= ST_STATE;
              end else if (free_found) begin
                res_status <= ST_OK;
              end else begin
                res_status <= ST_NO_SPACE;
              end
            end
            ACT_XLATE: begin
              res_status <= hit ? ST_OK : ST_NOT_FOUND;
              if (hit) begin
                res_phys <= phys_wide[PHYS_W-1:0];
              end
            end
            default: begin
              res_status <= hit ? ST_OK : ST_NOT_FOUND;
            end
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request fields for the walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      act     <= req.action;
      pid     <= req.process_id;
      frame   <= req.frame_number;
      wr_flag <= req.write_enable;
      offset  <= req.address[OFF_W-1:0];
      if (req.action == ACT_XLATE) begin
        key_page <= vpage_full[PAGE_W-1:0];
        key_ok   <= ((vpage_full >> PAGE_W) == '0);
      end else begin
        key_page <= req.page_number;
        key_ok   <= 1'b1;
      end
    end
  end

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_phys   <= res_phys;
    end
  end

endmodule

// File: tb/page_mapping_table_translate_tb.sv
// ----------------------------------------------------------------------------
// page_mapping_table_translate_tb
// Self-checking bench for the page mapping table. A shadow copy of the table
// predicts the status and physical address of every request. A short
// directed table covers the checks and extremes. Random phases then run at
// several frame_count settings, including zero and the full 17-bit value.
// ----------------------------------------------------------------------------
module page_mapping_table_translate_tb;
  import pmt_pkg::*;

  localparam int OFFS_W       = $clog2(PAGE_BYTES_DEF);
  localparam int PHASES       = 6;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int TAIL_CYCLES  = 80;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int SHOW_MAX     = 10;
  localparam bit PREDICT      = 1'b0;
  localparam bit TYPED        = 1'b1;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_LOOKUP} mix_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PID_W-1:0]    pid;
    logic [PAGE_W-1:0]   page;
    logic [ADDR_W-1:0]   addr;
    logic [FRAME_W-1:0]  frame;
    logic                wr;
    logic                live;
    logic                alloc;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHYS_W-1:0]   phys;
  } outcome_t;

  // One line of the directed table: the request and, where it is obvious,
  // the answer typed in by hand.
  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [FCOUNT_W-1:0] cfg_wdata;

  pmt_req_if req_if ();
  pmt_rsp_if rsp_if ();

  page_mapping_table_translate u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the mapping table and the frame_count register.
  logic                shadow_valid [TABLE_ENTRIES_DEF];
  pmt_entry_t          shadow_slot  [TABLE_ENTRIES_DEF];
  logic [FCOUNT_W-1:0] shadow_frame_count;

  // Answers still owed by the block, oldest first.
  outcome_t outcome_q [$];
  dir_row_t directed_rows [$];

  int requests_sent;
  int results_checked;
  int mismatch_count;
  int cycle_count;
  int status_seen [5];

  logic [FCOUNT_W-1:0] phase_fc  [PHASES] = '{17'd1000, 17'd131071, 17'd0,
                                              17'd65536, 17'd1, 17'd0};
  mix_t                phase_mix [PHASES] = '{MIX_BALANCED, MIX_FILL, MIX_LOOKUP,
                                              MIX_BALANCED, MIX_FILL, MIX_LOOKUP};
  int                  phase_len [PHASES] = '{80, 130, 40, 110, 60, 50};

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void clear_shadow();
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_slot[i]  = '0;
    end
  endfunction

  // Return the slot holding (pid, page), or -1. The page is passed wide so
  // that a page beyond 20 bits simply never matches.
  function automatic int find_mapping(input logic [PID_W-1:0] pid,
                                      input logic [63:0] page);
    int i;
    for (i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      if (shadow_valid[i] && shadow_slot[i].pid == pid &&
          64'(shadow_slot[i].page) == page)
        return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow table and return the answer it earns.
  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t    o;
    int          hit;
    int          free_slot;
    logic [63:0] vpage;
    logic [63:0] wide;
    o.status = ST_OK;
    o.phys   = '0;
    if (r.action == ACT_CLEAR) begin
      clear_shadow();
    end else if (r.pid == '0) begin
      o.status = ST_RANGE;
    end else if (!r.live) begin
      o.status = ST_NOT_FOUND;
    end else if (r.action == ACT_MAP) begin
      if ({1'b0, r.frame} >= shadow_frame_count) begin
        o.status = ST_RANGE;
      end else if (!r.alloc) begin
        o.status = ST_STATE;
      end else if (find_mapping(r.pid, 64'(r.page)) >= 0) begin
        o.status = ST_STATE;
      end else begin
        // Take the lowest free slot; none left means the table is full.
        free_slot = -1;
        for (int i = TABLE_ENTRIES_DEF - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          o.status = ST_NO_SPACE;
        end else begin
          shadow_valid[free_slot]         = 1'b1;
          shadow_slot[free_slot].pid      = r.pid;
          shadow_slot[free_slot].page     = r.page;
          shadow_slot[free_slot].frame    = r.frame;
          shadow_slot[free_slot].writable = r.wr;
        end
      end
    end else if (r.action == ACT_UNMAP) begin
      hit = find_mapping(r.pid, 64'(r.page));
      if (hit < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        shadow_valid[hit] = 1'b0;
        shadow_slot[hit]  = '0;
      end
    end else begin
      vpage = 64'(r.addr) / 64'(PAGE_BYTES_DEF);
      hit   = find_mapping(r.pid, vpage);
      if (hit < 0) begin
        o.status = ST_NOT_FOUND;
      end else begin
        wide   = 64'(shadow_slot[hit].frame) * 64'(PAGE_BYTES_DEF) +
                 64'(r.addr) % 64'(PAGE_BYTES_DEF);
        o.phys = wide[PHYS_W-1:0];
      end
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_row(input logic [ACTION_W-1:0] act, input int unsigned pid,
                         input int unsigned page, input logic [ADDR_W-1:0] addr,
                         input int unsigned frame, input bit wr, input bit live,
                         input bit alloc, input bit typed,
                         input logic [STATUS_W-1:0] st);
    dir_row_t row;
    row.req.action = act;
    row.req.pid    = PID_W'(pid);
    row.req.page   = PAGE_W'(page);
    row.req.addr   = addr;
    row.req.frame  = FRAME_W'(frame);
    row.req.wr     = wr;
    row.req.live   = live;
    row.req.alloc  = alloc;
    row.typed      = typed;
    row.want.status = st;
    row.want.phys   = '0;
    directed_rows.push_back(row);
  endtask

  // Draw a request. Keys come mostly from a small pool or from live entries
  // so that unmap and translate hit; fill phases use wide keys to reach a
  // full table.
  function automatic request_t random_request(input mix_t mix);
    request_t    r;
    int          roll;
    int          slots [$];
    int          pick;
    int unsigned top;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   r.action = (roll < 85) ? ACT_MAP : (roll < 90) ? ACT_UNMAP :
                             (roll < 99) ? ACT_XLATE : ACT_CLEAR;
      MIX_LOOKUP: r.action = (roll < 30) ? ACT_MAP : (roll < 55) ? ACT_UNMAP :
                             (roll < 97) ? ACT_XLATE : ACT_CLEAR;
      default:    r.action = (roll < 40) ? ACT_MAP : (roll < 60) ? ACT_UNMAP :
                             (roll < 96) ? ACT_XLATE : ACT_CLEAR;
    endcase
    r.pid   = PID_W'($urandom);
    r.page  = PAGE_W'($urandom);
    r.addr  = ADDR_W'($urandom);
    r.wr    = 1'($urandom);
    r.live  = ($urandom_range(0, 9) != 0);
    r.alloc = ($urandom_range(0, 9) != 0);

    if ($urandom_range(0, 3) != 0 && !(mix == MIX_FILL && r.action == ACT_MAP)) begin
      r.pid  = PID_W'($urandom_range(1, 6));
      r.page = PAGE_W'($urandom_range(0, 15));
    end
    // Reuse a stored key: mostly for lookups, now and then a duplicate map.
    if ($urandom_range(0, 9) < ((r.action == ACT_MAP) ? 1 : 6)) begin
      foreach (shadow_valid[i]) if (shadow_valid[i]) slots.push_back(i);
      if (slots.size() > 0) begin
        pick   = slots[$urandom_range(0, slots.size() - 1)];
        r.pid  = shadow_slot[pick].pid;
        r.page = shadow_slot[pick].page;
      end
    end
    if (r.action == ACT_XLATE && $urandom_range(0, 4) != 0)
      r.addr = {r.page, OFFS_W'($urandom)};
    if ($urandom_range(0, 29) == 0) r.pid = '0;

    // Frames: anywhere, inside the range, or right at its edge.
    top = (shadow_frame_count > 17'd65535) ? 65535 : int'(shadow_frame_count);
    case ($urandom_range(0, 2))
      0:       r.frame = FRAME_W'($urandom);
      1:       r.frame = FRAME_W'($urandom_range(0, (top == 0) ? 0 : top - 1));
      default: r.frame = FRAME_W'(top - ((top > 0) ? $urandom_range(0, 1) : 0));
    endcase
    return r;
  endfunction

  // Offer one request after a random gap, or none in burst stretches; record its answer on acceptance.
  task automatic issue_request(input request_t r, input logic typed,
                               input outcome_t typed_want);
    int       gap;
    outcome_t predicted;
    gap = (((requests_sent / 25) % 4) == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.process_id   <= r.pid;
    req_if.page_number  <= r.page;
    req_if.address      <= r.addr;
    req_if.frame_number <= r.frame;
    req_if.write_enable <= r.wr;
    req_if.process_live <= r.live;
    req_if.frame_in_use <= r.alloc;
    do @(posedge clk); while (!req_if.ready);
    predicted = predict_outcome(r);
    outcome_q.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  task automatic wait_all_results();
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_frame_count(input logic [FCOUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    shadow_frame_count = value;
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request side: reset, directed table, then random phases
  // --------------------------------------------------------------------------

  initial begin : stimulus
    outcome_t none;
    none = '0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_MAP;
    req_if.process_id   <= '0;
    req_if.page_number  <= '0;
    req_if.address      <= '0;
    req_if.frame_number <= '0;
    req_if.write_enable <= 1'b0;
    req_if.process_live <= 1'b0;
    req_if.frame_in_use <= 1'b0;
    clear_shadow();
    shadow_frame_count = FCOUNT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // act        pid      page      addr          frame   wr live alloc
    add_row(ACT_XLATE, 1,      0,       32'h0,        0,      0, 1, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_MAP,   0,      5,       32'h0,        5,      0, 1, 1, TYPED, ST_RANGE);
    add_row(ACT_UNMAP, 0,      5,       32'h0,        0,      0, 1, 1, TYPED, ST_RANGE);
    add_row(ACT_XLATE, 0,      0,       32'h5000,     0,      0, 1, 1, TYPED, ST_RANGE);
    add_row(ACT_MAP,   32767,  1,       32'h0,        1,      1, 0, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_UNMAP, 3,      1,       32'h0,        0,      0, 0, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_XLATE, 3,      0,       32'h1000,     0,      0, 0, 1, TYPED, ST_NOT_FOUND);
    // Frame not allocated, then the top key and top frame mapped for real.
    add_row(ACT_MAP,   32767,  'hFFFFF, 32'h0,        'hFFFF, 1, 1, 0, TYPED, ST_STATE);
    add_row(ACT_MAP,   32767,  'hFFFFF, 32'h0,        'hFFFF, 1, 1, 1, PREDICT, ST_OK);
    add_row(ACT_MAP,   32767,  'hFFFFF, 32'h0,        0,      0, 1, 1, TYPED, ST_STATE);
    add_row(ACT_XLATE, 32767,  0,       32'hFFFFFFFF, 0,      0, 1, 1, PREDICT, ST_OK);
    add_row(ACT_MAP,   1,      0,       32'h0,        0,      0, 1, 1, PREDICT, ST_OK);
    add_row(ACT_XLATE, 1,      0,       32'h0,        0,      0, 1, 1, PREDICT, ST_OK);
    add_row(ACT_XLATE, 1,      0,       32'h00000FFF, 0,      0, 1, 1, PREDICT, ST_OK);
    // Same page under another pid, and the next page under the same pid.
    add_row(ACT_XLATE, 2,      0,       32'h0,        0,      0, 1, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_XLATE, 1,      0,       32'h00001000, 0,      0, 1, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_UNMAP, 1,      0,       32'h0,        0,      0, 1, 1, PREDICT, ST_OK);
    add_row(ACT_UNMAP, 1,      0,       32'h0,        0,      0, 1, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_MAP,   'h2AAA, 'h55555, 32'h0,        'hAAAA, 1, 1, 1, PREDICT, ST_OK);
    add_row(ACT_XLATE, 'h2AAA, 0,       32'h55555555, 0,      0, 1, 1, PREDICT, ST_OK);
    // Clear ignores every other field, even a zero pid and dead process.
    add_row(ACT_CLEAR, 0,      'hFFFFF, 32'hFFFFFFFF, 'hFFFF, 1, 0, 0, TYPED, ST_OK);
    add_row(ACT_XLATE, 32767,  0,       32'hFFFFF000, 0,      0, 1, 1, TYPED, ST_NOT_FOUND);
    add_row(ACT_UNMAP, 'h2AAA, 'h55555, 32'h0,        0,      0, 1, 1, TYPED, ST_NOT_FOUND);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Drop valid and let the block go idle before each register write.
    phase_fc[PHASES-1] = FCOUNT_W'($urandom_range(2, 65535));
    for (int p = 0; p < PHASES; p++) begin
      req_if.valid <= 1'b0;
      wait_all_results();
      set_frame_count(phase_fc[p]);
      for (int n = 0; n < phase_len[p]; n++)
        issue_request(random_request(phase_mix[p]), PREDICT, none);
    end
    req_if.valid <= 1'b0;
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests over %0d frame_count settings, %0d responses checked",
             requests_sent, PHASES + 1, results_checked);
    $display("status mix: ok %0d, range %0d, not found %0d, conflict %0d, no space %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("page_mapping_table_translate: match");
    end else begin
      $display("page_mapping_table_translate: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: random stalls, quiet stretches and one long hold-off
  // --------------------------------------------------------------------------

  initial begin : rsp_drain
    int stall;
    int responses_taken;
    responses_taken = 0;
    rsp_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      // Hold off once for long enough that the block backs up into its input.
      if (responses_taken == HOLD_AT)
        stall = HOLD_CYCLES;
      else if (((responses_taken / 30) % 4) == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      responses_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOW_MAX)
      $display("response %0d: %s expected 0x%0h got 0x%0h",
               results_checked, what, want, got);
  endtask

  always @(posedge clk) begin : rsp_check
    outcome_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (rsp_if.status <= ST_NO_SPACE) status_seen[rsp_if.status]++;
      if (outcome_q.size() == 0) begin
        report_mismatch("unrequested response, status", 32'h0, 32'(rsp_if.status));
      end else begin
        want = outcome_q.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(rsp_if.status));
        if (rsp_if.physical_address !== want.phys)
          report_mismatch("physical_address", 32'(want.phys),
                          32'(rsp_if.physical_address));
      end
      results_checked++;
    end
  end

  // Give up if the run stalls.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses owed",
               cycle_count, outcome_q.size());
      $display("page_mapping_table_translate: mismatch");
      $finish;
    end
  end

endmodule
